// ===== hdl/loop_frame_link_checker_assert.svh =====
// Assertion macros used by the loop frame link checker top module.
`ifndef LOOP_FRAME_LINK_CHECKER_ASSERT_SVH
`define LOOP_FRAME_LINK_CHECKER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LFLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lflc assertion failed");

// Check a property on every clock edge, reset included.
`define LFLC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lflc assertion failed");

`endif

// ===== hdl/lflc_pkg.sv =====
// Types and constants of the loop frame link checker.
`default_nettype none

package lflc_pkg;

  // Record depth and the width of the saturating record counter
  localparam int RECORD_DEPTH = 16;
  localparam int CNT_W        = $clog2(RECORD_DEPTH + 1);
  localparam int SLOT_W       = 4;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // Frame layout
  localparam int FRAME_W   = 15;
  localparam int START_BIT = 14;
  localparam int CMD_BIT   = 10;
  localparam int STOP_BIT  = 0;
  localparam int PAR_BIT   = 1;

  typedef logic [FRAME_W-1:0] frame_t;

  // Opcode masking
  localparam logic [7:0] AWAIT_MASK8   = 8'h08;
  localparam logic [7:0] AWAIT_MASK16  = 8'h10;
  localparam logic [7:0] AWAIT_MASK32  = 8'h20;
  localparam logic [7:0] OP_MASK_F8    = 8'hF8;
  localparam logic [7:0] OP_MASK_F0    = 8'hF0;
  localparam logic [7:0] OP_MASK_NONE  = 8'hFF;
  localparam logic [7:0] TICKS_MAX     = 8'hFF;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_TICK = 2'd2
  } operation_t;

  typedef enum logic [3:0] {
    ST_SENT     = 4'd0,
    ST_WAITING  = 4'd1,
    ST_TIMEOUT  = 4'd2,
    ST_FRAMING  = 4'd3,
    ST_PARITY   = 4'd4,
    ST_CMD_MIS  = 4'd5,
    ST_ADDR_MIS = 4'd6,
    ST_OVERFLOW = 4'd7,
    ST_DATA_OK  = 4'd8,
    ST_CMD_OK   = 4'd9
  } status_t;

  // Checks on a received frame, from the codec to the top level
  typedef struct packed {
    logic       framing_err;
    logic       parity_err;
    logic       is_cmd;
    logic       op_match;
    logic [2:0] address;
    logic [7:0] data;
  } rx_chk_t;

endpackage

`default_nettype wire

// ===== hdl/lflc_if.sv =====
// Valid/ready channel interfaces of the loop frame link checker.
`default_nettype none

interface lflc_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [2:0]             dest_address;
  logic [7:0]             command_op;
  logic [7:0]             expected_reply_op;
  logic [7:0]             wait_limit;
  lflc_pkg::frame_t       rx_frame;

  modport source (
    output valid, operation, dest_address, command_op, expected_reply_op,
           wait_limit, rx_frame,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_address, command_op, expected_reply_op,
           wait_limit, rx_frame,
    output ready
  );
endinterface

interface lflc_out_if;
  logic                   valid;
  logic                   ready;
  logic [3:0]             status;
  lflc_pkg::frame_t       tx_frame;
  logic [2:0]             rx_address;
  logic [7:0]             rx_byte;
  lflc_pkg::slot_t        record_slot;

  modport source (
    output valid, status, tx_frame, rx_address, rx_byte, record_slot,
    input  ready
  );
  modport sink (
    input  valid, status, tx_frame, rx_address, rx_byte, record_slot,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/lflc_frame_codec.sv =====
// Frame encoder and receive checker of the loop frame link checker.
`default_nettype none

module lflc_frame_codec (
  input  wire logic [2:0]        dest_address,
  input  wire logic [7:0]        command_op,
  output lflc_pkg::frame_t       tx_frame,
  input  wire lflc_pkg::frame_t  rx_frame,
  input  wire logic [7:0]        awaited_op,
  output lflc_pkg::rx_chk_t      rx_chk
);

  logic [7:0] op_mask;

  // Build the command frame: start low, command flag and stop high, odd parity
  always_comb begin
    tx_frame                      = '0;
    tx_frame[lflc_pkg::STOP_BIT]  = 1'b1;
    tx_frame[9:2]                 = command_op;
    tx_frame[lflc_pkg::CMD_BIT]   = 1'b1;
    tx_frame[13:11]               = dest_address;
    tx_frame[lflc_pkg::PAR_BIT]   = ^tx_frame[13:2];
  end

  // Pick the opcode mask from the awaited opcode
  always_comb begin
    if (awaited_op == lflc_pkg::AWAIT_MASK8) begin
      op_mask = lflc_pkg::OP_MASK_F8;
    end else if (awaited_op == lflc_pkg::AWAIT_MASK16 ||
                 awaited_op == lflc_pkg::AWAIT_MASK32) begin
      op_mask = lflc_pkg::OP_MASK_F0;
    end else begin
      op_mask = lflc_pkg::OP_MASK_NONE;
    end
  end

  // Check framing, parity and the opcode of a received frame
  always_comb begin
    rx_chk.framing_err = rx_frame[lflc_pkg::START_BIT] | ~rx_frame[lflc_pkg::STOP_BIT];
    rx_chk.parity_err  = ~(^rx_frame);
    rx_chk.is_cmd      = rx_frame[lflc_pkg::CMD_BIT];
    rx_chk.address     = rx_frame[13:11];
    rx_chk.data        = rx_frame[9:2];
    rx_chk.op_match    = ((rx_frame[9:2] & op_mask) == awaited_op);
  end

endmodule

`default_nettype wire

// ===== hdl/loop_frame_link_checker.sv =====
// Loop frame link checker: command encoder and reply checker of a 15-bit serial loop master.
// Accepts one item (send, received frame or timer tick) per cycle unless the output stalls,
// and returns exactly one result per item: the item is captured in an input register, then
// a single stage of frame encoding, a 15-bit parity tree and a few compares feeds the result
// register. While a result waits, the input register can still take one new item.
// The wait and record state (awaited opcode, tick limit and counter, record address and
// count) updates as each item leaves the input register, so back-to-back items see it in order.
`default_nettype none

module loop_frame_link_checker (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lflc_in_if.sink    in_ch,
  lflc_out_if.source out_ch
);

  // Input register
  logic              in_vld_r;
  logic [1:0]        in_op_r;
  logic [2:0]        in_dest_r;
  logic [7:0]        in_cmd_op_r;
  logic [7:0]        in_exp_op_r;
  logic [7:0]        in_wait_r;
  lflc_pkg::frame_t  in_rx_r;

  // Result register
  logic              out_vld_r;
  logic [3:0]        out_status_r,   out_status_nxt;
  lflc_pkg::frame_t  out_tx_r,       out_tx_nxt;
  logic [2:0]        out_addr_r,     out_addr_nxt;
  logic [7:0]        out_byte_r,     out_byte_nxt;
  lflc_pkg::slot_t   out_slot_r,     out_slot_nxt;

  // Wait and record state
  logic [7:0]        awaited_op_r,   awaited_op_nxt;
  logic [7:0]        timeout_r,      timeout_nxt;
  logic [7:0]        elapsed_r,      elapsed_nxt;
  logic [2:0]        rec_addr_r,     rec_addr_nxt;
  lflc_pkg::cnt_t    rec_cnt_r,      rec_cnt_nxt;

  logic              advance;
  logic              in_take;
  lflc_pkg::frame_t  tx_frame;
  lflc_pkg::rx_chk_t rx_chk;
  logic [2:0]        rec_addr_eff;

  // Handshake: the input stage moves when the result register is free or drained
  assign advance      = ~out_vld_r | out_ch.ready;
  assign in_ch.ready  = ~in_vld_r | advance;
  assign in_take      = in_ch.valid & in_ch.ready;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.tx_frame    = out_tx_r;
  assign out_ch.rx_address  = out_addr_r;
  assign out_ch.rx_byte     = out_byte_r;
  assign out_ch.record_slot = out_slot_r;

  lflc_frame_codec u_codec (
    .dest_address (in_dest_r),
    .command_op   (in_cmd_op_r),
    .tx_frame     (tx_frame),
    .rx_frame     (in_rx_r),
    .awaited_op   (awaited_op_r),
    .rx_chk       (rx_chk)
  );

  // Compute the result and the next state of the held transaction
  always_comb begin
    out_status_nxt = lflc_pkg::ST_WAITING;
    out_tx_nxt     = '0;
    out_addr_nxt   = '0;
    out_byte_nxt   = '0;
    out_slot_nxt   = '0;
    awaited_op_nxt = awaited_op_r;
    timeout_nxt    = timeout_r;
    elapsed_nxt    = elapsed_r;
    rec_addr_nxt   = rec_addr_r;
    rec_cnt_nxt    = rec_cnt_r;
    rec_addr_eff   = (rec_addr_r == 3'd0) ? rx_chk.address : rec_addr_r;
    case (in_op_r)
      lflc_pkg::OP_SEND: begin
        out_status_nxt = lflc_pkg::ST_SENT;
        out_tx_nxt     = tx_frame;
        awaited_op_nxt = in_exp_op_r;
        timeout_nxt    = in_wait_r;
        elapsed_nxt    = '0;
        rec_addr_nxt   = in_dest_r;
        rec_cnt_nxt    = '0;
      end
      lflc_pkg::OP_RECV: begin
        out_addr_nxt = rx_chk.address;
        out_byte_nxt = rx_chk.data;
        if (rx_chk.framing_err) begin
          out_status_nxt = lflc_pkg::ST_FRAMING;
        end else if (rx_chk.parity_err) begin
          out_status_nxt = lflc_pkg::ST_PARITY;
        end else if (rx_chk.is_cmd) begin
          out_status_nxt = rx_chk.op_match ? lflc_pkg::ST_CMD_OK : lflc_pkg::ST_CMD_MIS;
        end else begin
          // Latch the record address from a data frame while it is still zero, then check it
          rec_addr_nxt = rec_addr_eff;
          if (rec_addr_eff != rx_chk.address) begin
            out_status_nxt = lflc_pkg::ST_ADDR_MIS;
          end else if (rec_cnt_r >= lflc_pkg::cnt_t'(lflc_pkg::RECORD_DEPTH)) begin
            out_status_nxt = lflc_pkg::ST_OVERFLOW;
          end else begin
            out_status_nxt = lflc_pkg::ST_DATA_OK;
            out_slot_nxt   = lflc_pkg::slot_t'(rec_cnt_r);
            rec_cnt_nxt    = rec_cnt_r + lflc_pkg::cnt_t'(1);
          end
        end
      end
      lflc_pkg::OP_TICK: begin
        // Age the wait counter, saturating
        if (elapsed_r != lflc_pkg::TICKS_MAX) begin
          elapsed_nxt = elapsed_r + 8'd1;
        end
        out_status_nxt = (elapsed_nxt > timeout_r) ? lflc_pkg::ST_TIMEOUT
                                                   : lflc_pkg::ST_WAITING;
      end
      default: begin
        out_status_nxt = lflc_pkg::ST_WAITING;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      awaited_op_r <= '0;
      timeout_r    <= '0;
      elapsed_r    <= '0;
      rec_addr_r   <= '0;
      rec_cnt_r    <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (advance && in_vld_r) begin
        awaited_op_r <= awaited_op_nxt;
        timeout_r    <= timeout_nxt;
        elapsed_r    <= elapsed_nxt;
        rec_addr_r   <= rec_addr_nxt;
        rec_cnt_r    <= rec_cnt_nxt;
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r     <= in_ch.operation;
      in_dest_r   <= in_ch.dest_address;
      in_cmd_op_r <= in_ch.command_op;
      in_exp_op_r <= in_ch.expected_reply_op;
      in_wait_r   <= in_ch.wait_limit;
      in_rx_r     <= in_ch.rx_frame;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_status_r <= out_status_nxt;
      out_tx_r     <= out_tx_nxt;
      out_addr_r   <= out_addr_nxt;
      out_byte_r   <= out_byte_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  `include "loop_frame_link_checker_assert.svh"

  `LFLC_ASSERT(a_cnt_bound, rec_cnt_r <= lflc_pkg::cnt_t'(lflc_pkg::RECORD_DEPTH))
  `LFLC_ASSERT(a_slot_cnt, (out_vld_r && out_status_r == lflc_pkg::ST_DATA_OK) |-> ((lflc_pkg::CNT_W + 1)'(rec_cnt_r) == (lflc_pkg::CNT_W + 1)'(out_slot_r) + 1'b1))
  `LFLC_ASSERT(a_tx_only_sent, (out_vld_r && out_status_r != lflc_pkg::ST_SENT) |-> (out_tx_r == '0))
  `LFLC_ASSERT(a_sent_clears, (out_vld_r && out_status_r == lflc_pkg::ST_SENT) |-> (elapsed_r == '0 && rec_cnt_r == '0))
  `LFLC_ASSERT(a_stall_holds, (in_vld_r && !advance) |=> in_vld_r)

endmodule

`default_nettype wire

// ===== bench/loop_frame_link_checker_tb.sv =====
// Testbench of the loop frame link checker: directed table, random exchanges, self-checking.
`timescale 1ns / 100ps

module loop_frame_link_checker_tb;

  // Operation code that the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Extra cycles run after the last result is checked
  localparam int unsigned DRAIN_CYCLES = 8;
  // Receiver hold-off that backs up the input side
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned HOLD_AFTER = 250;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [1:0]       operation;
    logic [2:0]       dest_address;
    logic [7:0]       command_op;
    logic [7:0]       expected_reply_op;
    logic [7:0]       wait_limit;
    lflc_pkg::frame_t rx_frame;
  } stim_t;

  typedef struct packed {
    logic [3:0]       status;
    lflc_pkg::frame_t tx_frame;
    logic [2:0]       rx_address;
    logic [7:0]       rx_byte;
    lflc_pkg::slot_t  record_slot;
  } outcome_t;

  // One queued transaction; typed rows carry their own expected result
  typedef struct packed {
    logic     typed;
    outcome_t want;
    stim_t    item;
  } entry_t;

  typedef struct packed {
    logic [8:0] reps;
    logic       typed;
    outcome_t   want;
    stim_t      item;
  } dir_row_t;

  localparam outcome_t PREDICTED = '0;
  localparam int DIR_ROWS = 26;

  // Directed table: reps, typed, expected result, transaction
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // after reset: first tick already exceeds a zero limit
    '{9'd1, 1'b1, '{lflc_pkg::ST_TIMEOUT, 15'h0000, 3'd0, 8'h00, 4'd0},
      '{lflc_pkg::OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0000}},
    // unused operation: all fields ignored
    '{9'd1, 1'b1, '{lflc_pkg::ST_WAITING, 15'h0000, 3'd0, 8'h00, 4'd0},
      '{OP_UNUSED, 3'd7, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF}},
    // framing: start bit set, then stop bit clear
    '{9'd1, 1'b1, '{lflc_pkg::ST_FRAMING, 15'h0000, 3'd7, 8'hFF, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h7FFF}},
    '{9'd1, 1'b1, '{lflc_pkg::ST_FRAMING, 15'h0000, 3'd0, 8'h00, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0000}},
    // even number of ones
    '{9'd1, 1'b1, '{lflc_pkg::ST_PARITY, 15'h0000, 3'd0, 8'h00, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0003}},
    // command opcode 0 matches the reset opcode
    '{9'd1, 1'b1, '{lflc_pkg::ST_CMD_OK, 15'h0000, 3'd0, 8'h00, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0403}},
    // first data frame sets the unknown record address
    '{9'd1, 1'b1, '{lflc_pkg::ST_DATA_OK, 15'h0000, 3'd5, 8'hA5, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h2A95}},
    '{9'd1, 1'b1, '{lflc_pkg::ST_ADDR_MIS, 15'h0000, 3'd3, 8'h3C, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h18F1}},
    // broadcast send awaiting the 0xF8-masked opcode
    '{9'd1, 1'b1, '{lflc_pkg::ST_SENT, 15'h0403, 3'd0, 8'h00, 4'd0},
      '{lflc_pkg::OP_SEND, 3'd0, 8'h00, 8'h08, 8'h02, 15'h0000}},
    '{9'd1, 1'b1, '{lflc_pkg::ST_CMD_OK, 15'h0000, 3'd0, 8'h0F, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h043F}},
    '{9'd1, 1'b1, '{lflc_pkg::ST_CMD_MIS, 15'h0000, 3'd0, 8'h10, 4'd0},
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0441}},
    '{9'd3, 1'b0, PREDICTED,
      '{lflc_pkg::OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0000}},
    // 0xF0 mask, limit one below saturation
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_SEND, 3'd2, 8'hFF, 8'h10, 8'hFE, 15'h0000}},
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h147F}},
    // tick counter saturates and keeps timing out
    '{9'd257, 1'b0, PREDICTED,
      '{lflc_pkg::OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0000}},
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_SEND, 3'd1, 8'h55, 8'h20, 8'h00, 15'h0000}},
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0CAB}},
    // fill the record, then overflow
    '{9'd17, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h099B}},
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h18F1}},
    // unmasked opcode
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_SEND, 3'd7, 8'h00, 8'hFF, 8'h01, 15'h0000}},
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h3FFD}},
    '{9'd2, 1'b0, PREDICTED,
      '{lflc_pkg::OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0000}},
    // full record at address 0: overflowing frame still sets the address
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_SEND, 3'd0, 8'hFF, 8'h00, 8'hFF, 15'h0000}},
    '{9'd16, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h0001}},
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h18F1}},
    '{9'd1, 1'b0, PREDICTED,
      '{lflc_pkg::OP_RECV, 3'd0, 8'h00, 8'h00, 8'h00, 15'h2A95}}
  };

  logic clk = 1'b0;
  logic rst_n;

  lflc_in_if  in_ch ();
  lflc_out_if out_ch ();

  loop_frame_link_checker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  entry_t      item_plan [$];
  outcome_t    response_q [$];
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;

  // Checker state as the predictor sees it
  logic [7:0]     want_op = '0;
  logic [7:0]     tick_limit = '0;
  logic [7:0]     tick_count = '0;
  logic [2:0]     rec_addr = '0;
  lflc_pkg::cnt_t rec_fill = '0;

  // Build a well-formed frame: bit 1 makes the total count of ones odd
  function automatic lflc_pkg::frame_t encode_frame(input logic [2:0] addr,
                                                    input logic is_cmd,
                                                    input logic [7:0] data);
    lflc_pkg::frame_t f;
    f = '0;
    f[lflc_pkg::STOP_BIT] = 1'b1;
    f[9:2] = data;
    f[lflc_pkg::CMD_BIT] = is_cmd;
    f[13:11] = addr;
    f[lflc_pkg::PAR_BIT] = ^f[13:2];
    return f;
  endfunction

  // Expected response of the checker to one transaction; advances the state
  function automatic outcome_t checker_response(input stim_t s);
    outcome_t         r;
    lflc_pkg::frame_t f;
    logic [7:0]       op;
    r = '0;
    r.status = lflc_pkg::ST_WAITING;
    case (s.operation)
      lflc_pkg::OP_SEND: begin
        r.tx_frame = encode_frame(s.dest_address, 1'b1, s.command_op);
        want_op = s.expected_reply_op;
        tick_limit = s.wait_limit;
        tick_count = '0;
        rec_addr = s.dest_address;
        rec_fill = '0;
        r.status = lflc_pkg::ST_SENT;
      end
      lflc_pkg::OP_RECV: begin
        f = s.rx_frame;
        r.rx_address = f[13:11];
        r.rx_byte = f[9:2];
        if (f[lflc_pkg::START_BIT] || !f[lflc_pkg::STOP_BIT]) begin
          r.status = lflc_pkg::ST_FRAMING;
        end else if (!(^f)) begin
          r.status = lflc_pkg::ST_PARITY;
        end else if (f[lflc_pkg::CMD_BIT]) begin
          op = f[9:2];
          if (want_op == lflc_pkg::AWAIT_MASK8) begin
            op = op & lflc_pkg::OP_MASK_F8;
          end else if (want_op == lflc_pkg::AWAIT_MASK16 ||
                       want_op == lflc_pkg::AWAIT_MASK32) begin
            op = op & lflc_pkg::OP_MASK_F0;
          end
          r.status = (op == want_op) ? lflc_pkg::ST_CMD_OK : lflc_pkg::ST_CMD_MIS;
        end else begin
          // a data frame fixes the record address while it is still zero
          if (rec_addr == '0) rec_addr = f[13:11];
          if (rec_addr != f[13:11]) begin
            r.status = lflc_pkg::ST_ADDR_MIS;
          end else if (rec_fill >= lflc_pkg::RECORD_DEPTH) begin
            r.status = lflc_pkg::ST_OVERFLOW;
          end else begin
            r.record_slot = rec_fill[lflc_pkg::SLOT_W-1:0];
            rec_fill = rec_fill + 1'b1;
            r.status = lflc_pkg::ST_DATA_OK;
          end
        end
      end
      lflc_pkg::OP_TICK: begin
        if (tick_count != lflc_pkg::TICKS_MAX) tick_count = tick_count + 1'b1;
        r.status = (tick_count > tick_limit) ? lflc_pkg::ST_TIMEOUT : lflc_pkg::ST_WAITING;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void plan_item(input stim_t s);
    entry_t e;
    e.typed = 1'b0;
    e.want = PREDICTED;
    e.item = s;
    item_plan.push_back(e);
  endfunction

  // Mostly command exchanges with random content, some noise and damaged frames
  task automatic plan_random(input int unsigned quota);
    stim_t       s;
    logic [2:0]  peer;
    logic [2:0]  data_addr;
    logic [2:0]  addr;
    logic [7:0]  want;
    logic [7:0]  keep;
    logic [7:0]  data;
    int unsigned planned;
    int unsigned burst;
    planned = 0;
    while (planned < quota) begin
      if ($urandom_range(9) < 7) begin
        peer = 3'($urandom_range(7));
        case ($urandom_range(4))
          0: want = lflc_pkg::AWAIT_MASK8;
          1: want = lflc_pkg::AWAIT_MASK16;
          2: want = lflc_pkg::AWAIT_MASK32;
          default: want = 8'($urandom);
        endcase
        if (want == lflc_pkg::AWAIT_MASK8) begin
          keep = lflc_pkg::OP_MASK_F8;
        end else if (want == lflc_pkg::AWAIT_MASK16 ||
                     want == lflc_pkg::AWAIT_MASK32) begin
          keep = lflc_pkg::OP_MASK_F0;
        end else begin
          keep = lflc_pkg::OP_MASK_NONE;
        end
        data_addr = (peer != 3'd0) ? peer : 3'($urandom_range(7));
        s = '0;
        s.operation = lflc_pkg::OP_SEND;
        s.dest_address = peer;
        s.command_op = 8'($urandom);
        s.expected_reply_op = want;
        s.wait_limit = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        plan_item(s);
        planned++;
        burst = ($urandom_range(5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
        repeat (burst) begin
          s = '0;
          case ($urandom_range(9))
            0, 1, 2: s.operation = lflc_pkg::OP_TICK;
            3, 4: begin
              s.operation = lflc_pkg::OP_RECV;
              data = ($urandom_range(3) == 0) ? 8'($urandom)
                                              : (want & keep) | (8'($urandom) & ~keep);
              s.rx_frame = encode_frame(3'($urandom), 1'b1, data);
            end
            default: begin
              s.operation = lflc_pkg::OP_RECV;
              addr = ($urandom_range(7) == 0) ? 3'($urandom) : data_addr;
              s.rx_frame = encode_frame(addr, 1'b0, 8'($urandom));
            end
          endcase
          // damage an occasional frame by one bit
          if (s.operation == lflc_pkg::OP_RECV && $urandom_range(11) == 0) begin
            s.rx_frame = s.rx_frame ^
                         (lflc_pkg::frame_t'(1) << $urandom_range(lflc_pkg::FRAME_W - 1));
          end
          plan_item(s);
          planned++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          s.operation = 2'($urandom);
          s.dest_address = 3'($urandom);
          s.command_op = 8'($urandom);
          s.expected_reply_op = 8'($urandom);
          s.wait_limit = 8'($urandom);
          s.rx_frame = lflc_pkg::frame_t'($urandom);
          plan_item(s);
          planned++;
        end
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [14:0] exp,
                                      input logic [14:0] got);
    if (got !== exp) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
      fail_count++;
    end
  endfunction

  // Predict each transaction taken by the block
  always @(posedge clk) begin : input_watch
    stim_t    s;
    outcome_t exp;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s.operation = in_ch.operation;
      s.dest_address = in_ch.dest_address;
      s.command_op = in_ch.command_op;
      s.expected_reply_op = in_ch.expected_reply_op;
      s.wait_limit = in_ch.wait_limit;
      s.rx_frame = in_ch.rx_frame;
      exp = checker_response(s);
      if (item_plan[items_taken].typed) exp = item_plan[items_taken].want;
      response_q.push_back(exp);
      items_taken++;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_watch
    outcome_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (response_q.size() == 0) begin
        $error("result with no expectation pending: status %0d", out_ch.status);
        fail_count++;
      end else begin
        exp = response_q.pop_front();
        check_field("status", exp.status, out_ch.status);
        check_field("tx_frame", exp.tx_frame, out_ch.tx_frame);
        check_field("rx_address", exp.rx_address, out_ch.rx_address);
        check_field("rx_byte", exp.rx_byte, out_ch.rx_byte);
        check_field("record_slot", exp.record_slot, out_ch.record_slot);
      end
    end
  end

  // Sender: reset, then the plan in bursts with random gaps
  initial begin : sender
    entry_t      e;
    int unsigned idx;
    int unsigned burst_left;
    int unsigned gap;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= '0;
    in_ch.dest_address <= '0;
    in_ch.command_op <= '0;
    in_ch.expected_reply_op <= '0;
    in_ch.wait_limit <= '0;
    in_ch.rx_frame <= '0;

    // expand the directed table, then append the random part
    for (int r = 0; r < DIR_ROWS; r++) begin
      e.typed = DIRECTED[r].typed;
      e.want = DIRECTED[r].want;
      e.item = DIRECTED[r].item;
      repeat (DIRECTED[r].reps) item_plan.push_back(e);
    end
    plan_random(RANDOM_ITEMS);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    burst_left = 0;
    while (idx < item_plan.size()) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      e = item_plan[idx];
      in_ch.valid <= 1'b1;
      in_ch.operation <= e.item.operation;
      in_ch.dest_address <= e.item.dest_address;
      in_ch.command_op <= e.item.command_op;
      in_ch.expected_reply_op <= e.item.expected_reply_op;
      in_ch.wait_limit <= e.item.wait_limit;
      in_ch.rx_frame <= e.item.rx_frame;
      // hold until the transaction is taken
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      idx++;
      burst_left--;
    end
    in_ch.valid <= 1'b0;

    // drain outstanding results
    while (items_taken < item_plan.size() || response_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("loop_frame_link_checker test passed");
    end else begin
      $display("loop_frame_link_checker test failed");
    end
    $finish;
  end

  // Receiver: stall on a rotating mask, with one long hold-off
  initial begin : receiver
    logic [15:0] stall_mask;
    int unsigned phase;
    int unsigned span;
    bit          held;
    out_ch.ready <= 1'b0;
    stall_mask = '1;
    phase = 0;
    span = 0;
    held = 1'b0;
    // wait for reset release; rst_n is still unknown at time zero
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && items_taken >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 96);
          case ($urandom_range(3))
            0, 1: stall_mask = '1;
            2: stall_mask = 16'($urandom);
            default: stall_mask = 16'h0101 << $urandom_range(7);
          endcase
          if (stall_mask == '0) stall_mask = 16'h0001;
        end
        out_ch.ready <= stall_mask[phase];
        phase = (phase + 1) % 16;
        span--;
        @(posedge clk);
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    #1_000_000;
    $display("loop_frame_link_checker test failed");
    $finish;
  end

endmodule
